>>> hdl/slru_pkg.sv
// Package: shared types, codes and saturating arithmetic for the slice cache.
`timescale 1ns / 1ps
package slru_pkg;

  // Link and index width; the all-ones code marks an empty list end
  localparam int unsigned LW = 6;
  localparam logic [LW-1:0] NIL = '1;

  localparam int unsigned DEF_ENTRIES     = 32;
  localparam int unsigned DEF_LENGTH_BITS = 24;

  localparam logic [31:0] BUDGET_RESET = 32'd2097152;

  typedef enum logic [1:0] {
    CFG_POLICY_MODE = 2'd0,
    CFG_BUDGET      = 2'd1,
    CFG_PROT_CAP    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_EVICT = 2'd0,
    KIND_HIT   = 2'd1,
    KIND_MISS  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_HIT,
    OP_DEMOTE,
    OP_EVICT,
    OP_INSERT
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_LRD,
    S_UNL,
    S_P0,
    S_P1,
    S_DEM,
    S_EVC,
    S_INS,
    S_ORD,
    S_OLD,
    S_OHOLD,
    S_OFIN
  } state_e;

  typedef struct packed {
    logic [15:0] tensor_id;
    logic [15:0] expert_index;
    logic [23:0] slice_length;
  } in_item_t;

  typedef struct packed {
    kind_e       result_kind;
    logic [15:0] slice_tensor;
    logic [15:0] slice_expert;
    logic [23:0] evicted_length;
    logic        promoted;
    logic [31:0] resident_after;
    logic        last_result;
  } out_item_t;

  // Writes to the three link stores, one port each
  typedef struct packed {
    logic          prot_we;
    logic [LW-1:0] prot_addr;
    logic          prot_d;
    logic          newer_we;
    logic [LW-1:0] newer_addr;
    logic [LW-1:0] newer_d;
    logic          older_we;
    logic [LW-1:0] older_addr;
    logic [LW-1:0] older_d;
  } link_wr_t;

  typedef struct packed {
    logic          prot;
    logic [LW-1:0] newer;
    logic [LW-1:0] older;
  } link_rd_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] floor_sub(input logic [31:0] a, input logic [31:0] b);
    return (a > b) ? (a - b) : 32'd0;
  endfunction

endpackage

>>> hdl/slru_entry_store.sv
// Entry store: key, length and link memories with one registered read address.
`timescale 1ns / 1ps
module slru_entry_store #(
  parameter int unsigned ENTRIES     = slru_pkg::DEF_ENTRIES,
  parameter int unsigned LENGTH_BITS = slru_pkg::DEF_LENGTH_BITS
) (
  input  logic                    clk_i,
  input  logic [slru_pkg::LW-1:0] rd_addr_i,
  input  logic                    key_we_i,
  input  logic [slru_pkg::LW-1:0] key_addr_i,
  input  logic [15:0]             key_tensor_i,
  input  logic [15:0]             key_expert_i,
  input  logic [LENGTH_BITS-1:0]  key_len_i,
  input  slru_pkg::link_wr_t      link_wr_i,
  output logic [15:0]             rd_tensor_o,
  output logic [15:0]             rd_expert_o,
  output logic [LENGTH_BITS-1:0]  rd_len_o,
  output slru_pkg::link_rd_t      rd_link_o
);
  import slru_pkg::*;

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [15:0]            tensor_mem [ENTRIES];
  logic [15:0]            expert_mem [ENTRIES];
  logic [LENGTH_BITS-1:0] len_mem    [ENTRIES];
  logic                   prot_mem   [ENTRIES];
  logic [LW-1:0]          newer_mem  [ENTRIES];
  logic [LW-1:0]          older_mem  [ENTRIES];

  // key and length writes
  always_ff @(posedge clk_i) begin
    if (key_we_i) begin
      tensor_mem[key_addr_i[AW-1:0]] <= key_tensor_i;
      expert_mem[key_addr_i[AW-1:0]] <= key_expert_i;
      len_mem[key_addr_i[AW-1:0]]    <= key_len_i;
    end
  end

  // link writes, independent addresses
  always_ff @(posedge clk_i) begin
    if (link_wr_i.prot_we) begin
      prot_mem[link_wr_i.prot_addr[AW-1:0]] <= link_wr_i.prot_d;
    end
    if (link_wr_i.newer_we) begin
      newer_mem[link_wr_i.newer_addr[AW-1:0]] <= link_wr_i.newer_d;
    end
    if (link_wr_i.older_we) begin
      older_mem[link_wr_i.older_addr[AW-1:0]] <= link_wr_i.older_d;
    end
  end

  // registered read of all fields at one entry
  always_ff @(posedge clk_i) begin
    rd_tensor_o     <= tensor_mem[rd_addr_i[AW-1:0]];
    rd_expert_o     <= expert_mem[rd_addr_i[AW-1:0]];
    rd_len_o        <= len_mem[rd_addr_i[AW-1:0]];
    rd_link_o.prot  <= prot_mem[rd_addr_i[AW-1:0]];
    rd_link_o.newer <= newer_mem[rd_addr_i[AW-1:0]];
    rd_link_o.older <= older_mem[rd_addr_i[AW-1:0]];
  end

endmodule

>>> hdl/slru_evict_buf.sv
// Eviction buffer: holds eviction notices of one touch until its total is known.
`timescale 1ns / 1ps
module slru_evict_buf #(
  parameter int unsigned ENTRIES     = slru_pkg::DEF_ENTRIES,
  parameter int unsigned LENGTH_BITS = slru_pkg::DEF_LENGTH_BITS
) (
  input  logic                    clk_i,
  input  logic                    wr_en_i,
  input  logic [slru_pkg::LW-1:0] wr_addr_i,
  input  logic [15:0]             wr_tensor_i,
  input  logic [15:0]             wr_expert_i,
  input  logic [LENGTH_BITS-1:0]  wr_len_i,
  input  logic [slru_pkg::LW-1:0] rd_addr_i,
  output logic [15:0]             rd_tensor_o,
  output logic [15:0]             rd_expert_o,
  output logic [LENGTH_BITS-1:0]  rd_len_o
);
  import slru_pkg::*;

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned RW = 32 + LENGTH_BITS;

  logic [RW-1:0] buf_mem [ENTRIES];
  logic [RW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      buf_mem[wr_addr_i[AW-1:0]] <= {wr_tensor_i, wr_expert_i, wr_len_i};
    end
    rd_q <= buf_mem[rd_addr_i[AW-1:0]];
  end

  assign rd_tensor_o = rd_q[RW-1 -: 16];
  assign rd_expert_o = rd_q[RW-17 -: 16];
  assign rd_len_o    = rd_q[LENGTH_BITS-1:0];

endmodule

>>> hdl/segmented_lru_byte_budget_cache.sv
// Top level: segmented LRU slice cache sequencer over the entry store.
`timescale 1ns / 1ps
// Usage
//   Input channel in_i/in_valid_i/in_stall_o carries one touch of a slice.
//   Output channel out_o/out_valid_o/out_stall_i carries its results: zero or
//   more eviction notices, then one final hit or miss with last_result set.
//   Every result of a touch carries the resident total after that touch.
//   Configuration: cfg_we_i/cfg_index_i/cfg_data_i, written while idle.
// Sequence
//   One touch at a time. The key lookup reads the entry store one entry per
//   cycle over all ENTRIES entries, stopping at a match. A hit reads the
//   target's links, unlinks it and pushes it at the newest end, then after a
//   promotion demotes protected tails while over the cap. A miss evicts tails
//   while over budget or full, then checks the budget and inserts. Results
//   leave through a single output register, eviction notices first and the
//   final result last; the sequencer then returns to idle before the next
//   touch is taken. The entry store has a single read port.
// Reset
//   Clears valid bits, list ends and totals; configuration returns to its
//   reset values. A stalled result holds in the output register until taken;
//   no new touch is accepted before the last result of the current one leaves.
module segmented_lru_byte_budget_cache #(
  parameter int unsigned ENTRIES     = slru_pkg::DEF_ENTRIES,
  parameter int unsigned LENGTH_BITS = slru_pkg::DEF_LENGTH_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slru_pkg::in_item_t  in_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output slru_pkg::out_item_t out_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import slru_pkg::*;

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [LW-1:0] ENT = LW'(ENTRIES);

  state_e                 state_q, state_d;
  op_e                    op_q, op_d;
  logic [15:0]            tid_q, tid_d, eid_q, eid_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [LW-1:0]          tgt_q, tgt_d, free_q, free_d, scan_q, scan_d;
  logic [LW-1:0]          pidx_q, pidx_d, nev_q, nev_d, rd_q, rd_d;
  logic                   pend_q, pend_d, push_prot_q, push_prot_d;
  logic                   promo_q, promo_d, hit_q, hit_d;
  logic [LW-1:0]          pb_new_q, pb_new_d, pb_old_q, pb_old_d;
  logic [LW-1:0]          pt_new_q, pt_new_d, pt_old_q, pt_old_d;
  logic [31:0]            resident_q, resident_d, ptotal_q, ptotal_d;
  logic [ENTRIES-1:0]     valid_q, valid_d;
  out_item_t              out_q, out_d;
  logic                   mode_q;
  logic [31:0]            budget_q, cap_q;

  // store interface
  logic [LW-1:0]          st_rd_addr;
  logic                   key_we;
  link_wr_t               link_wr;
  logic [15:0]            rd_tensor, rd_expert;
  logic [LENGTH_BITS-1:0] rd_len;
  link_rd_t               rd_link;

  // eviction buffer interface
  logic                   ev_we;
  logic [15:0]            ev_tensor, ev_expert;
  logic [LENGTH_BITS-1:0] ev_len;

  logic [31:0]            in_len32;
  logic [LW-1:0]          push_head;
  logic                   key_match;

  slru_entry_store #(
    .ENTRIES     (ENTRIES),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_store (
    .clk_i        (clk_i),
    .rd_addr_i    (st_rd_addr),
    .key_we_i     (key_we),
    .key_addr_i   (free_q),
    .key_tensor_i (tid_q),
    .key_expert_i (eid_q),
    .key_len_i    (len_q),
    .link_wr_i    (link_wr),
    .rd_tensor_o  (rd_tensor),
    .rd_expert_o  (rd_expert),
    .rd_len_o     (rd_len),
    .rd_link_o    (rd_link)
  );

  slru_evict_buf #(
    .ENTRIES     (ENTRIES),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_evbuf (
    .clk_i       (clk_i),
    .wr_en_i     (ev_we),
    .wr_addr_i   (nev_q),
    .wr_tensor_i (rd_tensor),
    .wr_expert_i (rd_expert),
    .wr_len_i    (rd_len),
    .rd_addr_i   (rd_q),
    .rd_tensor_o (ev_tensor),
    .rd_expert_o (ev_expert),
    .rd_len_o    (ev_len)
  );

  assign in_len32    = 32'(in_i.slice_length);
  assign push_head   = push_prot_q ? pt_new_q : pb_new_q;
  assign key_match   = pend_q && (rd_tensor == tid_q) && (rd_expert == eid_q);
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OHOLD) || (state_q == S_OFIN);
  assign out_o       = out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      budget_q <= BUDGET_RESET;
      cap_q    <= 32'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_POLICY_MODE: mode_q   <= cfg_data_i[0];
        CFG_BUDGET:      budget_q <= cfg_data_i;
        CFG_PROT_CAP:    cap_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_HIT;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      nev_q       <= '0;
      rd_q        <= '0;
      promo_q     <= 1'b0;
      hit_q       <= 1'b0;
      pb_new_q    <= NIL;
      pb_old_q    <= NIL;
      pt_new_q    <= NIL;
      pt_old_q    <= NIL;
      resident_q  <= 32'd0;
      ptotal_q    <= 32'd0;
      valid_q     <= '0;
      free_q      <= NIL;
      push_prot_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      nev_q       <= nev_d;
      rd_q        <= rd_d;
      promo_q     <= promo_d;
      hit_q       <= hit_d;
      pb_new_q    <= pb_new_d;
      pb_old_q    <= pb_old_d;
      pt_new_q    <= pt_new_d;
      pt_old_q    <= pt_old_d;
      resident_q  <= resident_d;
      ptotal_q    <= ptotal_d;
      valid_q     <= valid_d;
      free_q      <= free_d;
      push_prot_q <= push_prot_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tid_q  <= tid_d;
    eid_q  <= eid_d;
    len_q  <= len_d;
    tgt_q  <= tgt_d;
    pidx_q <= pidx_d;
    out_q  <= out_d;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    tid_d       = tid_q;
    eid_d       = eid_q;
    len_d       = len_q;
    tgt_d       = tgt_q;
    free_d      = free_q;
    scan_d      = scan_q;
    pidx_d      = pidx_q;
    pend_d      = pend_q;
    nev_d       = nev_q;
    rd_d        = rd_q;
    push_prot_d = push_prot_q;
    promo_d     = promo_q;
    hit_d       = hit_q;
    pb_new_d    = pb_new_q;
    pb_old_d    = pb_old_q;
    pt_new_d    = pt_new_q;
    pt_old_d    = pt_old_q;
    resident_d  = resident_q;
    ptotal_d    = ptotal_q;
    valid_d     = valid_q;
    out_d       = out_q;
    st_rd_addr  = tgt_q;
    key_we      = 1'b0;
    link_wr     = '0;
    ev_we       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          tid_d   = in_i.tensor_id;
          eid_d   = in_i.expert_index;
          len_d   = in_len32[LENGTH_BITS-1:0];
          scan_d  = '0;
          pend_d  = 1'b0;
          free_d  = NIL;
          nev_d   = '0;
          rd_d    = '0;
          promo_d = 1'b0;
          hit_d   = 1'b0;
          state_d = S_SCAN;
        end
      end

      // read one entry per cycle, compare the one read before
      S_SCAN: begin
        st_rd_addr = scan_q;
        if (key_match) begin
          tgt_d   = pidx_q;
          op_d    = OP_HIT;
          hit_d   = 1'b1;
          state_d = S_LRD;
        end else if (scan_q == ENT) begin
          state_d = S_EVC;
        end else begin
          pend_d = valid_q[scan_q[AW-1:0]];
          pidx_d = scan_q;
          if (!valid_q[scan_q[AW-1:0]] && (free_q == NIL)) begin
            free_d = scan_q;
          end
          scan_d = scan_q + 1'b1;
        end
      end

      S_LRD: begin
        st_rd_addr = tgt_q;
        state_d    = S_UNL;
      end

      // unlink the target, then finish per operation
      S_UNL: begin
        if (rd_link.newer < ENT) begin
          link_wr.older_we   = 1'b1;
          link_wr.older_addr = rd_link.newer;
          link_wr.older_d    = rd_link.older;
        end else if (rd_link.prot) begin
          pt_new_d = rd_link.older;
        end else begin
          pb_new_d = rd_link.older;
        end
        if (rd_link.older < ENT) begin
          link_wr.newer_we   = 1'b1;
          link_wr.newer_addr = rd_link.older;
          link_wr.newer_d    = rd_link.newer;
        end else if (rd_link.prot) begin
          pt_old_d = rd_link.newer;
        end else begin
          pb_old_d = rd_link.newer;
        end
        unique case (op_q)
          OP_HIT: begin
            if (rd_link.prot) begin
              push_prot_d = 1'b1;
            end else if (mode_q) begin
              push_prot_d = 1'b1;
              promo_d     = 1'b1;
              ptotal_d    = sat_add(ptotal_q, 32'(rd_len));
            end else begin
              push_prot_d = 1'b0;
            end
            state_d = S_P0;
          end
          OP_DEMOTE: begin
            ptotal_d    = floor_sub(ptotal_q, 32'(rd_len));
            push_prot_d = 1'b0;
            state_d     = S_P0;
          end
          OP_EVICT: begin
            resident_d = floor_sub(resident_q, 32'(rd_len));
            if (rd_link.prot) begin
              ptotal_d = floor_sub(ptotal_q, 32'(rd_len));
            end
            valid_d[tgt_q[AW-1:0]] = 1'b0;
            if ((free_q == NIL) || (tgt_q < free_q)) begin
              free_d = tgt_q;
            end
            ev_we   = 1'b1;
            nev_d   = nev_q + 1'b1;
            state_d = S_EVC;
          end
          OP_INSERT: begin
            state_d = S_IDLE;
          end
        endcase
      end

      // push at newest end: own links first, then the old head
      S_P0: begin
        link_wr.prot_we    = 1'b1;
        link_wr.prot_addr  = tgt_q;
        link_wr.prot_d     = push_prot_q;
        link_wr.older_we   = 1'b1;
        link_wr.older_addr = tgt_q;
        link_wr.older_d    = push_head;
        link_wr.newer_we   = 1'b1;
        link_wr.newer_addr = tgt_q;
        link_wr.newer_d    = NIL;
        state_d            = S_P1;
      end

      S_P1: begin
        if (push_head < ENT) begin
          link_wr.newer_we   = 1'b1;
          link_wr.newer_addr = push_head;
          link_wr.newer_d    = tgt_q;
        end else if (push_prot_q) begin
          pt_old_d = tgt_q;
        end else begin
          pb_old_d = tgt_q;
        end
        if (push_prot_q) begin
          pt_new_d = tgt_q;
        end else begin
          pb_new_d = tgt_q;
        end
        unique case (op_q)
          OP_HIT:    state_d = promo_q ? S_DEM : S_ORD;
          OP_DEMOTE: state_d = S_DEM;
          OP_INSERT: state_d = S_ORD;
          OP_EVICT:  state_d = S_IDLE;
        endcase
      end

      // demote protected tails while over the cap
      S_DEM: begin
        if ((ptotal_q > cap_q) && (pt_old_q < ENT)) begin
          tgt_d   = pt_old_q;
          op_d    = OP_DEMOTE;
          state_d = S_LRD;
        end else begin
          state_d = S_ORD;
        end
      end

      // evict tails while over budget or full
      S_EVC: begin
        if ((({1'b0, resident_q} + 33'(len_q) > {1'b0, budget_q}) || (free_q == NIL))
            && ((pb_old_q < ENT) || (pt_old_q < ENT)) && (nev_q < ENT)) begin
          tgt_d   = (pb_old_q < ENT) ? pb_old_q : pt_old_q;
          op_d    = OP_EVICT;
          state_d = S_LRD;
        end else begin
          state_d = S_INS;
        end
      end

      S_INS: begin
        if (free_q < ENT) begin
          key_we                  = 1'b1;
          valid_d[free_q[AW-1:0]] = 1'b1;
          resident_d              = sat_add(resident_q, 32'(len_q));
          tgt_d                   = free_q;
          op_d                    = OP_INSERT;
          push_prot_d             = 1'b0;
          state_d                 = S_P0;
        end else begin
          state_d = S_ORD;
        end
      end

      // drain buffered evictions, then the final result
      S_ORD: begin
        if (rd_q < nev_q) begin
          state_d = S_OLD;
        end else begin
          out_d.result_kind    = hit_q ? KIND_HIT : KIND_MISS;
          out_d.slice_tensor   = tid_q;
          out_d.slice_expert   = eid_q;
          out_d.evicted_length = 24'd0;
          out_d.promoted       = promo_q;
          out_d.resident_after = resident_q;
          out_d.last_result    = 1'b1;
          state_d              = S_OFIN;
        end
      end

      S_OLD: begin
        out_d.result_kind    = KIND_EVICT;
        out_d.slice_tensor   = ev_tensor;
        out_d.slice_expert   = ev_expert;
        out_d.evicted_length = 24'(ev_len);
        out_d.promoted       = 1'b0;
        out_d.resident_after = resident_q;
        out_d.last_result    = 1'b0;
        state_d              = S_OHOLD;
      end

      S_OHOLD: begin
        if (!out_stall_i) begin
          rd_d    = rd_q + 1'b1;
          state_d = S_ORD;
        end
      end

      S_OFIN: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

endmodule
